[rtl/lifd_pkg.sv]
// ----------------------------------------------------------------------------
// lifd_pkg
// Shared types and constants of the 6LoWPAN IPHC frame decompressor.
// ----------------------------------------------------------------------------
package lifd_pkg;

  localparam int unsigned MaxFrameBytes = 128;
  localparam int unsigned BytesW        = $clog2(MaxFrameBytes + 1);
  localparam int unsigned QueueDepth    = 2;

  // parse phases
  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_FC      = 5'd1;
  localparam logic [4:0] PH_SEQ     = 5'd2;
  localparam logic [4:0] PH_DPAN    = 5'd3;
  localparam logic [4:0] PH_DADDR   = 5'd4;
  localparam logic [4:0] PH_SPAN    = 5'd5;
  localparam logic [4:0] PH_SADDR   = 5'd6;
  localparam logic [4:0] PH_IPHC    = 5'd7;
  localparam logic [4:0] PH_CID     = 5'd8;
  localparam logic [4:0] PH_TF      = 5'd9;
  localparam logic [4:0] PH_NH      = 5'd10;
  localparam logic [4:0] PH_HLIM    = 5'd11;
  localparam logic [4:0] PH_SRC     = 5'd12;
  localparam logic [4:0] PH_DST     = 5'd13;
  localparam logic [4:0] PH_NHC     = 5'd14;
  localparam logic [4:0] PH_P0      = 5'd15;
  localparam logic [4:0] PH_P1      = 5'd16;
  localparam logic [4:0] PH_P2      = 5'd17;
  localparam logic [4:0] PH_P3      = 5'd18;
  localparam logic [4:0] PH_CKSUM   = 5'd19;
  localparam logic [4:0] PH_PAYLOAD = 5'd20;
  localparam logic [4:0] PH_DISCARD = 5'd21;

  // drop codes
  localparam logic [2:0] DROP_NONE     = 3'd0;
  localparam logic [2:0] DROP_TYPE     = 3'd1;
  localparam logic [2:0] DROP_DISPATCH = 3'd2;
  localparam logic [2:0] DROP_NHC      = 3'd3;
  localparam logic [2:0] DROP_TRUNC    = 3'd4;

  localparam logic [5:0] HdrBytes    = 6'd40;
  localparam logic [5:0] HdrUdpBytes = 6'd48;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_DROP,
    KIND_HDR
  } kind_e;

  typedef struct packed {
    kind_e         kind;
    logic [7:0]    data;
    logic          last;
    logic [2:0]    code;
    logic          udp;
    logic [27:0]   traffic_flow;
    logic [15:0]   plen;
    logic [15:0]   next_hdr_hop;
    logic [127:0]  src;
    logic [127:0]  dst;
    logic [47:0]   ports_check;
  } cmd_t;

endpackage

[rtl/lowpan_iphc_frame_decompressor_unit.sv]
// ----------------------------------------------------------------------------
// lowpan_iphc_frame_decompressor_unit
// Rebuilds IPv6 (and UDP) headers from 802.15.4 frames carrying 6LoWPAN IPHC.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                       | payload
//  frame   | in        | frame_valid_i / frame_ready_o   | frame_byte, frame_length, frame_end
//  packet  | out       | packet_valid_o / packet_ready_i | packet_byte, packet_end, drop_code
//
//  The parser takes one frame word per cycle whenever the two-entry command
//  queue has room. Header words leave at one per cycle while packet_ready_i is
//  high: a finished header is 40 words (48 with UDP) on the output, set by the
//  byte sequencer. Payload and drop commands give one word each. Sustained rate
//  is one word per cycle; output stalls back up through the queue to frame_ready_o.
//  Reset clears the parser to wait for a quality byte and empties the queue.
// ----------------------------------------------------------------------------
module lowpan_iphc_frame_decompressor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       frame_valid_i,
  output logic       frame_ready_o,
  input  logic [7:0] frame_byte_i,
  input  logic [7:0] frame_length_i,
  input  logic       frame_end_i,
  output logic       packet_valid_o,
  input  logic       packet_ready_i,
  output logic [7:0] packet_byte_o,
  output logic       packet_end_o,
  output logic [2:0] drop_code_o
);
  import lifd_pkg::*;

  logic take;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  logic q_full;
  logic q_pop;
  cmd_t q_cmd;

  // Accept a frame word only while the queue can take its command.
  assign frame_ready_o = !q_full;
  assign take = frame_valid_i && frame_ready_o;

  lifd_front u_front (
    .clk_i,
    .rst_ni,
    .take_i         (take),
    .frame_byte_i,
    .frame_length_i,
    .frame_end_i,
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  lifd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .cmd_o   (q_cmd)
  );

  lifd_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .packet_valid_o,
    .packet_ready_i,
    .packet_byte_o,
    .packet_end_o,
    .drop_code_o
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("command queue overflow");

  // A drop word always closes its frame.
  a_drop_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (packet_valid_o && drop_code_o != DROP_NONE) |-> packet_end_o)
    else $error("drop word without end mark");

  // Pop only when a command is waiting.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // An idle sequencer with queued work must be busy next cycle.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !packet_valid_o) |=> packet_valid_o)
    else $error("sequencer failed to load");

endmodule

[rtl/lifd_front.sv]
// ----------------------------------------------------------------------------
// lifd_front
// Frame parser: takes one byte per accept, tracks the compressed header
// fields and issues byte, drop and header commands.
// ----------------------------------------------------------------------------
module lifd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     frame_byte_i,
  input  logic [7:0]     frame_length_i,
  input  logic           frame_end_i,
  output logic           push_o,
  output lifd_pkg::cmd_t cmd_o
);
  import lifd_pkg::*;

  logic [4:0]        phase_q, phase_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic [15:0]       fc_q, fc_d, iphc_q, iphc_d, nhh_q, nhh_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [63:0]       ldst_q, ldst_d, lsrc_q, lsrc_d;
  logic [27:0]       tf_q, tf_d;
  logic [127:0]      src_q, src_d, dst_q, dst_d;
  logic [47:0]       upc_q, upc_d;
  logic              uc_q, uc_d;

  function automatic logic [4:0] field_len(logic [4:0] p, logic [15:0] fc,
                                           logic [15:0] iw, logic uc);
    logic [1:0] dm;
    logic [1:0] sm;
    logic [4:0] n;
    dm = fc[11:10];
    sm = fc[15:14];
    n  = 5'd0;
    case (p)
      PH_FC:    n = 5'd2;
      PH_SEQ:   n = 5'd1;
      PH_DPAN:  n = (dm != 2'd0) ? 5'd2 : 5'd0;
      PH_DADDR: n = (dm == 2'd2) ? 5'd2 : ((dm == 2'd3) ? 5'd8 : 5'd0);
      PH_SPAN:  n = (sm != 2'd0 && !fc[6]) ? 5'd2 : 5'd0;
      PH_SADDR: n = (sm == 2'd2) ? 5'd2 : ((sm == 2'd3) ? 5'd8 : 5'd0);
      PH_IPHC:  n = 5'd2;
      PH_CID:   n = {4'd0, iw[7]};
      PH_TF: begin
        case (iw[12:11])
          2'd0:    n = 5'd4;
          2'd1:    n = 5'd3;
          2'd2:    n = 5'd1;
          default: n = 5'd0;
        endcase
      end
      PH_NH:    n = iw[10] ? 5'd0 : 5'd1;
      PH_HLIM:  n = (iw[9:8] != 2'd0) ? 5'd0 : 5'd1;
      PH_SRC: begin
        case (iw[6:4])
          3'd0:         n = 5'd16;
          3'd1, 3'd5:   n = 5'd8;
          3'd2, 3'd6:   n = 5'd2;
          default:      n = 5'd0;
        endcase
      end
      PH_DST: begin
        case (iw[3:0])
          4'd0, 4'd8:   n = 5'd16;
          4'd1, 4'd5:   n = 5'd8;
          4'd2, 4'd6:   n = 5'd2;
          4'd9, 4'd12:  n = 5'd6;
          4'd10:        n = 5'd4;
          4'd11:        n = 5'd1;
          default:      n = 5'd0;
        endcase
      end
      PH_NHC:   n = {4'd0, iw[10]};
      PH_P0:    n = 5'd4;
      PH_P1:    n = 5'd3;
      PH_P2:    n = 5'd3;
      PH_P3:    n = 5'd1;
      PH_CKSUM: n = uc ? 5'd0 : 5'd2;
      default:  n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] next_phase(logic [4:0] p);
    logic [4:0] r;
    r = p + 5'd1;
    if (p == PH_NHC || p == PH_CKSUM) begin
      r = PH_PAYLOAD;
    end else if (p >= PH_P0 && p <= PH_P3) begin
      r = PH_CKSUM;
    end
    return r;
  endfunction

  function automatic logic [63:0] iid_of(logic [1:0] mode, logic [63:0] addr);
    logic [63:0] r;
    r = 64'd0;
    if (mode == 2'd2) begin
      r = 64'h0000_00ff_fe00_0000 | {48'd0, addr[15:0]};
    end else if (mode == 2'd3) begin
      r = addr ^ 64'h0200_0000_0000_0000;
    end
    return r;
  endfunction

  logic [7:0]  b;
  logic [3:0]  k;
  logic [4:0]  cnt_n;
  logic [4:0]  p;
  logic [2:0]  code;
  logic        last;
  logic        nhc_hit;
  logic [15:0] rem;
  logic [2:0]  sam;
  logic [3:0]  dam;
  logic [3:0]  pos;
  logic        put_src;
  logic        put_dst;
  logic [2:0]  ppos;
  logic        put_p;
  logic        sh8;

  always_comb begin
    phase_d = phase_q; bytes_d = bytes_q; fc_d = fc_q; iphc_d = iphc_q;
    nhh_d = nhh_q; cnt_d = cnt_q; ldst_d = ldst_q; lsrc_d = lsrc_q;
    tf_d = tf_q; src_d = src_q; dst_d = dst_q; upc_d = upc_q; uc_d = uc_q;
    push_o = 1'b0;
    cmd_o = '0;
    b = frame_byte_i;
    k = cnt_q;
    cnt_n = {1'b0, cnt_q} + 5'd1;
    p = phase_q;
    code = DROP_NONE;
    last = 1'b0;
    nhc_hit = 1'b0;
    rem = 16'd0;
    sam = 3'd0;
    dam = 4'd0;
    pos = 4'd0;
    put_src = 1'b0;
    put_dst = 1'b0;
    ppos = 3'd0;
    put_p = 1'b0;
    sh8 = 1'b0;

    if (phase_q >= PH_DISCARD) begin
      if (frame_end_i) begin
        phase_d = PH_IDLE;
      end
    end else if (phase_q == PH_IDLE) begin
      fc_d = '0; iphc_d = '0; nhh_d = '0; cnt_d = '0; ldst_d = '0; lsrc_d = '0;
      tf_d = '0; src_d = '0; dst_d = '0; upc_d = '0; uc_d = 1'b0;
      bytes_d = BytesW'(1);
      if (frame_end_i) begin
        push_o = 1'b1;
        cmd_o.kind = KIND_DROP;
        cmd_o.code = DROP_TRUNC;
        phase_d = PH_IDLE;
      end else begin
        phase_d = PH_FC;
      end
    end else begin
      bytes_d = bytes_q + BytesW'(1);
      last = frame_end_i || (bytes_d >= BytesW'(MaxFrameBytes));
      if (phase_q == PH_PAYLOAD) begin
        push_o = 1'b1;
        cmd_o.kind = KIND_BYTE;
        cmd_o.data = b;
        cmd_o.last = last;
        if (last) begin
          phase_d = frame_end_i ? PH_IDLE : PH_DISCARD;
        end
      end else begin
        case (phase_q)
          PH_FC: begin
            if (k[0]) begin
              fc_d[15:8] = fc_q[15:8] | b;
              if (fc_d[2:0] != 3'd1) code = DROP_TYPE;
            end else begin
              fc_d[7:0] = fc_q[7:0] | b;
            end
          end
          PH_DADDR: ldst_d[{k[2:0], 3'b000} +: 8] = ldst_q[{k[2:0], 3'b000} +: 8] | b;
          PH_SADDR: lsrc_d[{k[2:0], 3'b000} +: 8] = lsrc_q[{k[2:0], 3'b000} +: 8] | b;
          PH_IPHC: begin
            if (k == 4'd0) begin
              iphc_d = {b, 8'd0};
              if (b[7:5] != 3'd3) code = DROP_DISPATCH;
            end else begin
              iphc_d = {iphc_q[15:8], b};
              sam = iphc_d[6:4];
              dam = iphc_d[3:0];
              tf_d = '0;
              case (iphc_d[9:8])
                2'd0:    nhh_d = 16'd0;
                2'd1:    nhh_d = 16'd1;
                2'd2:    nhh_d = 16'd64;
                default: nhh_d = 16'd255;
              endcase
              src_d = '0;
              dst_d = '0;
              if (sam >= 3'd1 && sam <= 3'd3) src_d[127:64] = 64'hfe80_0000_0000_0000;
              if (sam == 3'd2) src_d[63:0] = 64'h0000_00ff_fe00_0000;
              if (sam == 3'd3) src_d[63:0] = iid_of(fc_q[15:14], lsrc_q);
              if (dam >= 4'd1 && dam <= 4'd3) dst_d[127:64] = 64'hfe80_0000_0000_0000;
              if (dam == 4'd2) dst_d[63:0] = 64'h0000_00ff_fe00_0000;
              if (dam == 4'd3) dst_d[63:0] = iid_of(fc_q[11:10], ldst_q);
              if (dam == 4'd9 || dam == 4'd10) dst_d[127:64] = 64'hff00_0000_0000_0000;
              if (dam == 4'd11) dst_d[127:64] = 64'hff02_0000_0000_0000;
            end
          end
          PH_TF: begin
            if (k == 4'd0) begin
              if (iphc_q[12:11] == 2'd1) begin
                tf_d = {6'd0, b[7:6], b[3:0], 16'd0};
              end else begin
                tf_d = {b[5:0], b[7:6], 20'd0};
              end
            end else if (iphc_q[12:11] == 2'd0 && k == 4'd1) begin
              tf_d[19:16] = tf_q[19:16] | b[3:0];
            end else begin
              sh8 = (iphc_q[12:11] == 2'd0) ? (k == 4'd2) : (k == 4'd1);
              if (sh8) tf_d[15:8] = tf_q[15:8] | b;
              else tf_d[7:0] = tf_q[7:0] | b;
            end
          end
          PH_NH:   nhh_d[15:8] = b;
          PH_HLIM: nhh_d[7:0] = b;
          PH_SRC: begin
            case (iphc_q[6:4])
              3'd0: begin put_src = 1'b1; pos = k; end
              3'd1: begin put_src = 1'b1; pos = 4'd8 + k; end
              3'd2: begin put_src = 1'b1; pos = 4'd14 + k; end
              default: put_src = 1'b0;
            endcase
            if (put_src) src_d[{~pos, 3'b000} +: 8] = b;
          end
          PH_DST: begin
            case (iphc_q[3:0])
              4'd0, 4'd8: begin put_dst = 1'b1; pos = k; end
              4'd1:  begin put_dst = 1'b1; pos = 4'd8 + k; end
              4'd2:  begin put_dst = 1'b1; pos = 4'd14 + k; end
              4'd9:  begin put_dst = 1'b1; pos = (k != 4'd0) ? 4'd10 + k : 4'd1; end
              4'd10: begin put_dst = 1'b1; pos = (k != 4'd0) ? 4'd12 + k : 4'd1; end
              4'd11: begin put_dst = 1'b1; pos = 4'd15; end
              default: put_dst = 1'b0;
            endcase
            if (put_dst) dst_d[{~pos, 3'b000} +: 8] = b;
          end
          PH_NHC: begin
            if ((b & 8'hf8) != 8'hf0) begin
              code = DROP_NHC;
            end else begin
              nhc_hit = 1'b1;
              nhh_d[15:8] = 8'd17;
              uc_d = b[2];
              case (b[1:0])
                2'd1:    upc_d = {16'd0, 16'hf000, 16'd0};
                2'd2:    upc_d = {16'hf000, 32'd0};
                default: upc_d = '0;
              endcase
              phase_d = PH_P0 + {3'd0, b[1:0]};
              cnt_d = '0;
            end
          end
          PH_P0: begin put_p = 1'b1; ppos = {1'b0, k[1:0]}; end
          PH_P1: begin put_p = 1'b1; ppos = (k == 4'd2) ? 3'd3 : {2'd0, k[0]}; end
          PH_P2: begin put_p = 1'b1; ppos = k[2:0] + 3'd1; end
          PH_P3: upc_d = {16'hf0b0 | {12'd0, b[7:4]}, 16'hf0b0 | {12'd0, b[3:0]}, 16'd0};
          PH_CKSUM: begin put_p = 1'b1; ppos = 3'd4 + {2'd0, k[0]}; end
          default: code = DROP_NONE;
        endcase
        if (put_p) upc_d[{3'(3'd5 - ppos), 3'b000} +: 8] = b;

        if (code == DROP_NONE && !nhc_hit) begin
          if (cnt_n >= field_len(phase_q, fc_d, iphc_d, uc_d)) begin
            cnt_d = '0;
            p = next_phase(phase_q);
            for (int i = 0; i < 9; i++) begin
              if (p != PH_PAYLOAD && field_len(p, fc_d, iphc_d, uc_d) == 5'd0) begin
                p = next_phase(p);
              end
            end
            phase_d = p;
          end else begin
            cnt_d = cnt_n[3:0];
          end
        end

        if (code != DROP_NONE) begin
          push_o = 1'b1;
          cmd_o.kind = KIND_DROP;
          cmd_o.code = code;
          phase_d = frame_end_i ? PH_IDLE : PH_DISCARD;
        end else if (phase_d == PH_PAYLOAD) begin
          rem = ({8'd0, frame_length_i} > 16'(bytes_d)) ?
                ({8'd0, frame_length_i} - 16'(bytes_d)) : 16'd0;
          push_o = 1'b1;
          cmd_o.kind = KIND_HDR;
          cmd_o.last = last;
          cmd_o.udp = iphc_d[10];
          cmd_o.traffic_flow = tf_d;
          cmd_o.plen = rem + (iphc_d[10] ? 16'd8 : 16'd0);
          cmd_o.next_hdr_hop = nhh_d;
          cmd_o.src = src_d;
          cmd_o.dst = dst_d;
          cmd_o.ports_check = upc_d;
          if (last) phase_d = frame_end_i ? PH_IDLE : PH_DISCARD;
        end else if (last) begin
          push_o = 1'b1;
          cmd_o.kind = KIND_DROP;
          cmd_o.code = DROP_TRUNC;
          phase_d = frame_end_i ? PH_IDLE : PH_DISCARD;
        end
      end
    end
    if (!take_i) push_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; bytes_q <= '0; fc_q <= '0; iphc_q <= '0; nhh_q <= '0;
      cnt_q <= '0; ldst_q <= '0; lsrc_q <= '0; tf_q <= '0; src_q <= '0;
      dst_q <= '0; upc_q <= '0; uc_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d; bytes_q <= bytes_d; fc_q <= fc_d; iphc_q <= iphc_d;
      nhh_q <= nhh_d; cnt_q <= cnt_d; ldst_q <= ldst_d; lsrc_q <= lsrc_d;
      tf_q <= tf_d; src_q <= src_d; dst_q <= dst_d; upc_q <= upc_d; uc_q <= uc_d;
    end
  end

endmodule

[rtl/lifd_queue.sv]
// ----------------------------------------------------------------------------
// lifd_queue
// Short command queue between the parser and the byte sequencer.
// ----------------------------------------------------------------------------
module lifd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lifd_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output lifd_pkg::cmd_t cmd_o
);
  import lifd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(QueueDepth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(QueueDepth));
  assign cmd_o   = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i) rd_q <= bump(rd_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/lifd_back.sv]
// ----------------------------------------------------------------------------
// lifd_back
// Byte sequencer: holds one command and plays it out one word per accept.
// ----------------------------------------------------------------------------
module lifd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  lifd_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           packet_valid_o,
  input  logic           packet_ready_i,
  output logic [7:0]     packet_byte_o,
  output logic           packet_end_o,
  output logic [2:0]     drop_code_o
);
  import lifd_pkg::*;

  logic       busy_q;
  cmd_t       cmd_q;
  logic [5:0] idx_q;
  logic [5:0] count;
  logic       final_word;
  logic       advance;
  logic       done;
  logic [7:0] hdr_byte;
  logic [3:0] off;
  logic [7:0] tc;

  assign count      = (cmd_q.kind == KIND_HDR) ? (cmd_q.udp ? HdrUdpBytes : HdrBytes) : 6'd1;
  assign final_word = (idx_q == count - 6'd1);
  assign advance    = busy_q && packet_ready_i;
  assign done       = advance && final_word;
  assign q_pop_o    = q_valid_i && (!busy_q || done);
  assign packet_valid_o = busy_q;
  assign tc = cmd_q.traffic_flow[27:20];

  always_comb begin
    off = 4'(idx_q - 6'd8);
    hdr_byte = 8'd0;
    if (idx_q < 6'd8) begin
      case (idx_q[2:0])
        3'd0:    hdr_byte = {4'h6, tc[7:4]};
        3'd1:    hdr_byte = {tc[3:0], cmd_q.traffic_flow[19:16]};
        3'd2:    hdr_byte = cmd_q.traffic_flow[15:8];
        3'd3:    hdr_byte = cmd_q.traffic_flow[7:0];
        3'd4:    hdr_byte = cmd_q.plen[15:8];
        3'd5:    hdr_byte = cmd_q.plen[7:0];
        3'd6:    hdr_byte = cmd_q.next_hdr_hop[15:8];
        default: hdr_byte = cmd_q.next_hdr_hop[7:0];
      endcase
    end else if (idx_q < 6'd24) begin
      hdr_byte = cmd_q.src[{~off, 3'b000} +: 8];
    end else if (idx_q < 6'd40) begin
      off = 4'(idx_q - 6'd24);
      hdr_byte = cmd_q.dst[{~off, 3'b000} +: 8];
    end else begin
      case (idx_q[2:0])
        3'd0:    hdr_byte = cmd_q.ports_check[47:40];
        3'd1:    hdr_byte = cmd_q.ports_check[39:32];
        3'd2:    hdr_byte = cmd_q.ports_check[31:24];
        3'd3:    hdr_byte = cmd_q.ports_check[23:16];
        3'd4:    hdr_byte = cmd_q.plen[15:8];
        3'd5:    hdr_byte = cmd_q.plen[7:0];
        3'd6:    hdr_byte = cmd_q.ports_check[15:8];
        default: hdr_byte = cmd_q.ports_check[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cmd_q.kind)
      KIND_BYTE: begin
        packet_byte_o = cmd_q.data;
        packet_end_o  = cmd_q.last;
        drop_code_o   = DROP_NONE;
      end
      KIND_DROP: begin
        packet_byte_o = 8'd0;
        packet_end_o  = 1'b1;
        drop_code_o   = cmd_q.code;
      end
      KIND_HDR: begin
        packet_byte_o = hdr_byte;
        packet_end_o  = cmd_q.last && final_word;
        drop_code_o   = DROP_NONE;
      end
      default: begin
        packet_byte_o = 8'd0;
        packet_end_o  = 1'b0;
        drop_code_o   = DROP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (advance) begin
      idx_q <= idx_q + 6'd1;
    end
  end

endmodule
